[hdl/test_frame_generator_defines.svh]
// ---------------------------------------------------------------------------
// Test frame generator: assertion macros
// Shared helpers for the concurrent checks of the frame generator.
// ---------------------------------------------------------------------------
`ifndef TEST_FRAME_GENERATOR_DEFINES_SVH
`define TEST_FRAME_GENERATOR_DEFINES_SVH

// Same-cycle implication, gated by reset
`define TFG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfg: same-cycle check failed");

// Next-cycle implication, gated by reset
`define TFG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfg: next-cycle check failed");

`endif

[hdl/tfg_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfg_pkg
// Types, header constants and frame-geometry helpers of the test frame
// generator.
// ---------------------------------------------------------------------------
package tfg_pkg;

  // Limits
  localparam int unsigned MAX_PAYLOAD = 1400;
  localparam int unsigned MIN_FRAME   = 60;

  // Configuration port
  localparam int unsigned CFG_AW = 6;
  localparam int unsigned CFG_DW = 64;

  // Register indexes
  localparam logic [2:0] REG_DEST_MAC   = 3'd0;
  localparam logic [2:0] REG_SOURCE_MAC = 3'd1;
  localparam logic [2:0] REG_SRC_IP_UP  = 3'd2;
  localparam logic [2:0] REG_SRC_IP_LO  = 3'd3;
  localparam logic [2:0] REG_DST_IP_UP  = 3'd4;
  localparam logic [2:0] REG_DST_IP_LO  = 3'd5;
  localparam logic [2:0] REG_FLOW_PORTS = 3'd6;
  localparam logic [2:0] REG_FRAME_MODE = 3'd7;

  localparam logic [13:0] FRAME_MODE_RESET = 14'd32;

  // Protocol select codes (code three frames as ICMP, but its checksum includes the pseudo-header)
  localparam logic [1:0] PROTO_UDP  = 2'd0;
  localparam logic [1:0] PROTO_TCP  = 2'd1;
  localparam logic [1:0] PROTO_ICMP = 2'd2;

  // IP protocol numbers
  localparam logic [7:0] IPPROTO_UDP   = 8'd17;
  localparam logic [7:0] IPPROTO_TCP   = 8'd6;
  localparam logic [7:0] IPPROTO_ICMP  = 8'd1;
  localparam logic [7:0] IPPROTO_ICMP6 = 8'd58;

  // Header bytes
  localparam logic [7:0] ETYPE4_HI    = 8'h08;
  localparam logic [7:0] ETYPE4_LO    = 8'h00;
  localparam logic [7:0] ETYPE6_HI    = 8'h86;
  localparam logic [7:0] ETYPE6_LO    = 8'hdd;
  localparam logic [7:0] IP4_VER_IHL  = 8'h45;
  localparam logic [7:0] IP6_VER      = 8'h60;
  localparam logic [7:0] TAG_HI       = 8'h13;  // IPv4 id and TCP seq top half
  localparam logic [7:0] TAG_LO       = 8'h37;
  localparam logic [7:0] IP4_FLAG_DF  = 8'h40;
  localparam logic [7:0] HOP_LIMIT    = 8'd64;
  localparam logic [7:0] TCP_SEQ_B2   = 8'h00;
  localparam logic [7:0] TCP_SEQ_B3   = 8'h01;
  localparam logic [7:0] TCP_DOFF     = 8'h50;
  localparam logic [7:0] TCP_SYN      = 8'h02;
  localparam logic [7:0] TCP_WIN      = 8'hff;
  localparam logic [7:0] ICMP4_ECHO   = 8'd8;
  localparam logic [7:0] ICMP6_ECHO   = 8'd128;
  localparam logic [7:0] PAYLOAD_FILL = 8'h5a;
  localparam logic [15:0] UDP_ZERO_CSUM = 16'hffff;

  // Lengths
  localparam logic [10:0] IP4_HDR_LEN = 11'd20;
  localparam logic [4:0]  UDP_HDR_LEN = 5'd8;
  localparam logic [4:0]  TCP_HDR_LEN = 5'd20;
  localparam logic [5:0]  L4_OFF_V4   = 6'd34;
  localparam logic [5:0]  L4_OFF_V6   = 6'd54;
  localparam logic [10:0] ETH_HDR_LEN = 11'd14;

  // Fixed word sums used by the checksum pipeline
  localparam logic [17:0] IP4_FIXED_SUM = 18'({IP4_VER_IHL, 8'h00}) + 18'({TAG_HI, TAG_LO})
                                        + 18'({IP4_FLAG_DF, 8'h00}) + 18'({HOP_LIMIT, 8'h00});
  localparam logic [17:0] TCP_FIXED_SUM = 18'({TAG_HI, TAG_LO}) + 18'({TCP_SEQ_B2, TCP_SEQ_B3})
                                        + 18'({TCP_DOFF, TCP_SYN}) + 18'({TCP_WIN, TCP_WIN});
  localparam logic [15:0] PAY_WORD     = {PAYLOAD_FILL, PAYLOAD_FILL};
  localparam logic [15:0] PAY_ODD_WORD = {PAYLOAD_FILL, 8'h00};

  // Configuration registers
  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [63:0] source_ip_upper;
    logic [63:0] source_ip_lower;
    logic [63:0] dest_ip_upper;
    logic [63:0] dest_ip_lower;
    logic [31:0] flow_ports;
    logic [13:0] frame_mode;
  } tfg_cfg_t;

  // One register write beat
  typedef struct packed {
    logic              en;
    logic [2:0]        idx;
    logic [CFG_DW-1:0] data;
  } tfg_cfg_wr_t;

  function automatic logic mode_v6(logic [13:0] mode);
    return mode[13];
  endfunction

  function automatic logic [1:0] mode_proto(logic [13:0] mode);
    return mode[12:11];
  endfunction

  // Payload length, saturated
  function automatic logic [10:0] mode_pay(logic [13:0] mode);
    return (mode[10:0] > 11'(MAX_PAYLOAD)) ? 11'(MAX_PAYLOAD) : mode[10:0];
  endfunction

  function automatic logic [4:0] l4_hdr_len(logic [1:0] proto);
    return (proto == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN;
  endfunction

  function automatic logic [5:0] l4_off(logic v6);
    return v6 ? L4_OFF_V6 : L4_OFF_V4;
  endfunction

  function automatic logic [7:0] l4_proto_num(logic [1:0] proto, logic v6);
    logic [7:0] n;
    if (proto == PROTO_UDP) begin
      n = IPPROTO_UDP;
    end else if (proto == PROTO_TCP) begin
      n = IPPROTO_TCP;
    end else begin
      n = v6 ? IPPROTO_ICMP6 : IPPROTO_ICMP;
    end
    return n;
  endfunction

  // Total frame length including padding
  function automatic logic [10:0] frame_len(logic [13:0] mode);
    logic [10:0] f;
    f = 11'(l4_off(mode_v6(mode))) + 11'(l4_hdr_len(mode_proto(mode))) + mode_pay(mode);
    return (f < 11'(MIN_FRAME)) ? 11'(MIN_FRAME) : f;
  endfunction

  // Byte k of a 128-bit word, byte zero most significant
  function automatic logic [7:0] pick_byte(logic [127:0] v, logic [3:0] k);
    logic [127:0] s;
    s = v >> {~k, 3'b000};
    return s[7:0];
  endfunction

  // End-around carry fold and complement
  function automatic logic [15:0] fold_not(logic [24:0] s);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = {1'b0, s[15:0]} + {8'b0, s[24:16]};
    f2 = f1[15:0] + {15'b0, f1[16]};
    return ~f2;
  endfunction

endpackage

[hdl/tfg_byte_gen.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfg_byte_gen
// Selects the frame byte at a given position from the configuration and the
// latched checksums.
// ---------------------------------------------------------------------------
module tfg_byte_gen
  import tfg_pkg::*;
(
  input  tfg_cfg_t    cfg,
  input  logic [10:0] pos,
  input  logic [15:0] hdr_csum,
  input  logic [15:0] l4_csum,
  output logic [7:0]  frame_byte
);

  always_comb begin
    logic          v6;
    logic [1:0]    proto;
    logic [10:0]   pay;
    logic [10:0]   ll;
    logic [10:0]   tot;
    logic [10:0]   o4;
    logic [4:0]    hl;
    logic [5:0]    lo;
    logic [5:0]    oip;
    logic [7:0]    l4p;
    logic [127:0]  ip_src;
    logic [127:0]  ip_dst;
    logic [15:0]   sport;
    logic [15:0]   dport;
    logic [3:0]    mk;

    v6     = mode_v6(cfg.frame_mode);
    proto  = mode_proto(cfg.frame_mode);
    pay    = mode_pay(cfg.frame_mode);
    hl     = l4_hdr_len(proto);
    ll     = 11'(hl) + pay;
    tot    = ll + IP4_HDR_LEN;
    lo     = l4_off(v6);
    l4p    = l4_proto_num(proto, v6);
    sport  = cfg.flow_ports[31:16];
    dport  = cfg.flow_ports[15:0];
    ip_src = v6 ? {cfg.source_ip_upper, cfg.source_ip_lower}
                : {96'b0, cfg.source_ip_lower[31:0]};
    ip_dst = v6 ? {cfg.dest_ip_upper, cfg.dest_ip_lower}
                : {96'b0, cfg.dest_ip_lower[31:0]};
    oip    = 6'(pos - ETH_HDR_LEN);
    o4     = pos - 11'(lo);
    mk     = '0;

    frame_byte = '0;
    if (pos < 11'd12) begin
      // MAC addresses sit in the low six bytes of a 128-bit word
      if (pos < 11'd6) begin
        mk = 4'd10 + pos[3:0];
        frame_byte = pick_byte({80'b0, cfg.dest_mac}, mk);
      end else begin
        mk = 4'd4 + pos[3:0];
        frame_byte = pick_byte({80'b0, cfg.source_mac}, mk);
      end
    end else if (pos == 11'd12) begin
      frame_byte = v6 ? ETYPE6_HI : ETYPE4_HI;
    end else if (pos == 11'd13) begin
      frame_byte = v6 ? ETYPE6_LO : ETYPE4_LO;
    end else if (pos < 11'(lo)) begin
      if (!v6) begin
        // IPv4 header
        unique case (oip)
          6'd0:    frame_byte = IP4_VER_IHL;
          6'd2:    frame_byte = {5'b0, tot[10:8]};
          6'd3:    frame_byte = tot[7:0];
          6'd4:    frame_byte = TAG_HI;
          6'd5:    frame_byte = TAG_LO;
          6'd6:    frame_byte = IP4_FLAG_DF;
          6'd8:    frame_byte = HOP_LIMIT;
          6'd9:    frame_byte = l4p;
          6'd10:   frame_byte = hdr_csum[15:8];
          6'd11:   frame_byte = hdr_csum[7:0];
          default: begin
            if (oip >= 6'd12 && oip < 6'd16) begin
              frame_byte = pick_byte(ip_src, oip[3:0]);
            end else if (oip >= 6'd16 && oip < 6'd20) begin
              frame_byte = pick_byte(ip_dst, 4'(oip - 6'd4));
            end
          end
        endcase
      end else begin
        // IPv6 header
        unique case (oip)
          6'd0:    frame_byte = IP6_VER;
          6'd4:    frame_byte = {5'b0, ll[10:8]};
          6'd5:    frame_byte = ll[7:0];
          6'd6:    frame_byte = l4p;
          6'd7:    frame_byte = HOP_LIMIT;
          default: begin
            if (oip >= 6'd8 && oip < 6'd24) begin
              frame_byte = pick_byte(ip_src, 4'(oip - 6'd8));
            end else if (oip >= 6'd24 && oip < 6'd40) begin
              frame_byte = pick_byte(ip_dst, 4'(oip - 6'd24));
            end
          end
        endcase
      end
    end else if (o4 >= ll) begin
      frame_byte = '0;
    end else if (o4 >= 11'(hl)) begin
      frame_byte = PAYLOAD_FILL;
    end else if (proto == PROTO_UDP) begin
      unique case (o4[4:0])
        5'd0:    frame_byte = sport[15:8];
        5'd1:    frame_byte = sport[7:0];
        5'd2:    frame_byte = dport[15:8];
        5'd3:    frame_byte = dport[7:0];
        5'd4:    frame_byte = {5'b0, ll[10:8]};
        5'd5:    frame_byte = ll[7:0];
        5'd6:    frame_byte = l4_csum[15:8];
        default: frame_byte = l4_csum[7:0];
      endcase
    end else if (proto == PROTO_TCP) begin
      // SYN segment
      unique case (o4[4:0])
        5'd0:    frame_byte = sport[15:8];
        5'd1:    frame_byte = sport[7:0];
        5'd2:    frame_byte = dport[15:8];
        5'd3:    frame_byte = dport[7:0];
        5'd4:    frame_byte = TAG_HI;
        5'd5:    frame_byte = TAG_LO;
        5'd6:    frame_byte = TCP_SEQ_B2;
        5'd7:    frame_byte = TCP_SEQ_B3;
        5'd12:   frame_byte = TCP_DOFF;
        5'd13:   frame_byte = TCP_SYN;
        5'd14:   frame_byte = TCP_WIN;
        5'd15:   frame_byte = TCP_WIN;
        5'd16:   frame_byte = l4_csum[15:8];
        5'd17:   frame_byte = l4_csum[7:0];
        default: frame_byte = '0;
      endcase
    end else begin
      // Echo request
      unique case (o4[4:0])
        5'd0:    frame_byte = v6 ? ICMP6_ECHO : ICMP4_ECHO;
        5'd2:    frame_byte = l4_csum[15:8];
        5'd3:    frame_byte = l4_csum[7:0];
        5'd4:    frame_byte = sport[15:8];
        5'd5:    frame_byte = sport[7:0];
        5'd6:    frame_byte = dport[15:8];
        5'd7:    frame_byte = dport[7:0];
        default: frame_byte = '0;
      endcase
    end
  end

endmodule

[hdl/tfg_csum.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfg_csum
// Internet checksum pipeline: address word sums kept per register write,
// then four stages from frame start to the latched IPv4 and L4 checksums.
// ---------------------------------------------------------------------------
module tfg_csum
  import tfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  tfg_cfg_wr_t cfg_wr,
  input  tfg_cfg_t    cfg,
  output logic [15:0] hdr_csum,
  output logic [15:0] l4_csum
);

  function automatic logic [17:0] wsum4(logic [63:0] v);
    return 18'(v[63:48]) + 18'(v[47:32]) + 18'(v[31:16]) + 18'(v[15:0]);
  endfunction

  function automatic logic [16:0] wsum2(logic [31:0] v);
    return 17'(v[31:16]) + 17'(v[15:0]);
  endfunction

  // Word sums, refreshed on each write to their register
  logic [17:0] sup_sum_r, slo_sum_r, dup_sum_r, dlo_sum_r;
  logic [16:0] s4_sum_r, d4_sum_r, port_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_sum_r  <= '0;
      slo_sum_r  <= '0;
      dup_sum_r  <= '0;
      dlo_sum_r  <= '0;
      s4_sum_r   <= '0;
      d4_sum_r   <= '0;
      port_sum_r <= '0;
    end else if (cfg_wr.en) begin
      if (cfg_wr.idx == REG_SRC_IP_UP) begin
        sup_sum_r <= wsum4(cfg_wr.data);
      end
      if (cfg_wr.idx == REG_SRC_IP_LO) begin
        slo_sum_r <= wsum4(cfg_wr.data);
        s4_sum_r  <= wsum2(cfg_wr.data[31:0]);
      end
      if (cfg_wr.idx == REG_DST_IP_UP) begin
        dup_sum_r <= wsum4(cfg_wr.data);
      end
      if (cfg_wr.idx == REG_DST_IP_LO) begin
        dlo_sum_r <= wsum4(cfg_wr.data);
        d4_sum_r  <= wsum2(cfg_wr.data[31:0]);
      end
      if (cfg_wr.idx == REG_FLOW_PORTS) begin
        port_sum_r <= wsum2(cfg_wr.data[31:0]);
      end
    end
  end

  // Stage A: capture mode, address sum and port sum at frame start
  logic        a_go_r;
  logic        a_v6_r;
  logic [1:0]  a_proto_r;
  logic [10:0] a_pay_r;
  logic [19:0] a_addr_r;
  logic [16:0] a_ports_r;
  logic [19:0] a_addr_nxt;

  always_comb begin
    if (mode_v6(cfg.frame_mode)) begin
      a_addr_nxt = 20'(sup_sum_r) + 20'(slo_sum_r) + 20'(dup_sum_r) + 20'(dlo_sum_r);
    end else begin
      a_addr_nxt = 20'(s4_sum_r) + 20'(d4_sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_go_r <= 1'b0;
    end else begin
      a_go_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_v6_r    <= mode_v6(cfg.frame_mode);
      a_proto_r <= mode_proto(cfg.frame_mode);
      a_pay_r   <= mode_pay(cfg.frame_mode);
      a_addr_r  <= a_addr_nxt;
      a_ports_r <= port_sum_r;
    end
  end

  // Stage B: header sums and payload sum
  logic        b_go_r;
  logic        b_v6_r;
  logic        b_udp_r;
  logic [20:0] b_hsum_r;
  logic [21:0] b_l4hdr_r;
  logic [23:0] b_pay_r;
  logic [20:0] b_hsum_nxt;
  logic [21:0] b_l4hdr_nxt;
  logic [23:0] b_pay_nxt;

  always_comb begin
    logic [10:0] ll;
    logic [10:0] tot;
    logic [7:0]  l4p;
    logic [20:0] pseudo;
    logic [17:0] words;
    logic [25:0] prod;

    ll   = 11'(l4_hdr_len(a_proto_r)) + a_pay_r;
    tot  = ll + IP4_HDR_LEN;
    l4p  = l4_proto_num(a_proto_r, a_v6_r);

    b_hsum_nxt = 21'(IP4_FIXED_SUM) + 21'(tot) + 21'(l4p) + 21'(a_addr_r);

    // Pseudo-header, absent only for the plain ICMP code over IPv4
    if (a_proto_r == PROTO_ICMP && !a_v6_r) begin
      pseudo = '0;
    end else begin
      pseudo = 21'(a_addr_r) + 21'(ll) + 21'(l4p);
    end

    if (a_proto_r == PROTO_UDP) begin
      words = 18'(a_ports_r) + 18'(ll);
    end else if (a_proto_r == PROTO_TCP) begin
      words = 18'(a_ports_r) + TCP_FIXED_SUM;
    end else begin
      words = 18'(a_ports_r) + 18'({a_v6_r ? ICMP6_ECHO : ICMP4_ECHO, 8'h00});
    end
    b_l4hdr_nxt = 22'(pseudo) + 22'(words);

    // Fill bytes start on an even offset: whole words plus an odd high byte
    prod      = 26'(PAY_WORD) * 26'(a_pay_r[10:1]);
    b_pay_nxt = prod[23:0] + (a_pay_r[0] ? 24'(PAY_ODD_WORD) : 24'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_go_r <= 1'b0;
    end else begin
      b_go_r <= a_go_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go_r) begin
      b_v6_r    <= a_v6_r;
      b_udp_r   <= (a_proto_r == PROTO_UDP);
      b_hsum_r  <= b_hsum_nxt;
      b_l4hdr_r <= b_l4hdr_nxt;
      b_pay_r   <= b_pay_nxt;
    end
  end

  // Stage C: full L4 sum
  logic        c_go_r;
  logic        c_v6_r;
  logic        c_udp_r;
  logic [20:0] c_hsum_r;
  logic [24:0] c_l4sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_go_r <= 1'b0;
    end else begin
      c_go_r <= b_go_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go_r) begin
      c_v6_r    <= b_v6_r;
      c_udp_r   <= b_udp_r;
      c_hsum_r  <= b_hsum_r;
      c_l4sum_r <= 25'(b_l4hdr_r) + 25'(b_pay_r);
    end
  end

  // Stage D: fold, complement, latch
  logic [15:0] hdr_csum_r, l4_csum_r;
  logic [15:0] hdr_csum_nxt, l4_csum_nxt;

  always_comb begin
    hdr_csum_nxt = c_v6_r ? 16'd0 : fold_not(25'(c_hsum_r));
    l4_csum_nxt  = fold_not(c_l4sum_r);
    if (c_udp_r && l4_csum_nxt == 16'd0) begin
      l4_csum_nxt = UDP_ZERO_CSUM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_csum_r <= '0;
      l4_csum_r  <= '0;
    end else if (c_go_r) begin
      hdr_csum_r <= hdr_csum_nxt;
      l4_csum_r  <= l4_csum_nxt;
    end
  end

  assign hdr_csum = hdr_csum_r;
  assign l4_csum  = l4_csum_r;

endmodule

[hdl/test_frame_generator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// test_frame_generator
// Byte-wide Ethernet test frame source with IPv4/IPv6 and UDP/TCP/ICMP.
// ---------------------------------------------------------------------------
// Each accepted beat on the input channel yields exactly one frame byte on
// the output channel, one beat per clock when neither side stalls. The byte
// is selected by a single pass of logic from the position counter and the
// configuration and lands in a two-entry output buffer, so in_stall comes
// straight from a flop and rises only once two bytes are waiting. Byte zero of
// each frame launches the checksum pipeline; its results are latched
// well before the first checksum byte (frame offset 24) can be reached. The
// configuration registers sit at byte address 8*index with 64-bit data.
// ---------------------------------------------------------------------------
`include "test_frame_generator_defines.svh"

module test_frame_generator
  import tfg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_frame_byte,
  output logic [10:0]       out_byte_offset,
  output logic              out_last_byte,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [10:0] offset;
    logic        last;
  } beat_t;

  // Configuration registers
  tfg_cfg_t    cfg_r, cfg_nxt;
  tfg_cfg_wr_t cfg_wr;

  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[CFG_AW-1 -: 3];
  assign cfg_wr.data = pwdata;
  assign pready      = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.en) begin
      unique case (cfg_wr.idx)
        REG_DEST_MAC:   cfg_nxt.dest_mac        = cfg_wr.data[47:0];
        REG_SOURCE_MAC: cfg_nxt.source_mac      = cfg_wr.data[47:0];
        REG_SRC_IP_UP:  cfg_nxt.source_ip_upper = cfg_wr.data;
        REG_SRC_IP_LO:  cfg_nxt.source_ip_lower = cfg_wr.data;
        REG_DST_IP_UP:  cfg_nxt.dest_ip_upper   = cfg_wr.data;
        REG_DST_IP_LO:  cfg_nxt.dest_ip_lower   = cfg_wr.data;
        REG_FLOW_PORTS: cfg_nxt.flow_ports      = cfg_wr.data[31:0];
        REG_FRAME_MODE: cfg_nxt.frame_mode      = cfg_wr.data[13:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{frame_mode: FRAME_MODE_RESET, default: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[CFG_AW-1 -: 3])
      REG_DEST_MAC:   prdata = CFG_DW'(cfg_r.dest_mac);
      REG_SOURCE_MAC: prdata = CFG_DW'(cfg_r.source_mac);
      REG_SRC_IP_UP:  prdata = cfg_r.source_ip_upper;
      REG_SRC_IP_LO:  prdata = cfg_r.source_ip_lower;
      REG_DST_IP_UP:  prdata = cfg_r.dest_ip_upper;
      REG_DST_IP_LO:  prdata = cfg_r.dest_ip_lower;
      REG_FLOW_PORTS: prdata = CFG_DW'(cfg_r.flow_ports);
      REG_FRAME_MODE: prdata = CFG_DW'(cfg_r.frame_mode);
      default:        prdata = '0;
    endcase
  end

  // Position tracking
  logic [10:0] pos_r, pos_nxt;
  logic [10:0] flen;
  logic [10:0] eff_pos;
  logic        gen_last;
  logic        in_accept;
  logic        csum_start;

  assign flen       = frame_len(cfg_r.frame_mode);
  assign eff_pos    = (in_restart || pos_r >= flen) ? 11'd0 : pos_r;
  assign gen_last   = (eff_pos + 11'd1) == flen;
  assign in_accept  = in_valid && !in_stall;
  assign csum_start = in_accept && (eff_pos == 11'd0);

  always_comb begin
    pos_nxt = pos_r;
    if (in_accept) begin
      pos_nxt = gen_last ? 11'd0 : eff_pos + 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Checksums and byte select
  logic [15:0] hdr_csum, l4_csum;
  logic [7:0]  gen_byte;

  tfg_csum u_csum (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (csum_start),
    .cfg_wr   (cfg_wr),
    .cfg      (cfg_r),
    .hdr_csum (hdr_csum),
    .l4_csum  (l4_csum)
  );

  tfg_byte_gen u_byte_gen (
    .cfg        (cfg_r),
    .pos        (eff_pos),
    .hdr_csum   (hdr_csum),
    .l4_csum    (l4_csum),
    .frame_byte (gen_byte)
  );

  // Two-entry output buffer: main drives the port, skid catches a stalled beat
  beat_t new_beat;
  beat_t main_beat_r, main_beat_nxt;
  beat_t skid_beat_r, skid_beat_nxt;
  logic  main_valid_r, main_valid_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  logic  out_take;

  assign new_beat = '{frame_byte: gen_byte, offset: eff_pos, last: gen_last};
  assign out_take = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_beat_nxt  = main_beat_r;
    skid_beat_nxt  = skid_beat_r;
    if (skid_valid_r) begin
      if (out_take) begin
        main_beat_nxt  = skid_beat_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_accept) begin
      if (!main_valid_r || out_take) begin
        main_beat_nxt  = new_beat;
        main_valid_nxt = 1'b1;
      end else begin
        skid_beat_nxt  = new_beat;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_beat_r <= main_beat_nxt;
    skid_beat_r <= skid_beat_nxt;
  end

  assign in_stall        = skid_valid_r;
  assign out_valid       = main_valid_r;
  assign out_frame_byte  = main_beat_r.frame_byte;
  assign out_byte_offset = main_beat_r.offset;
  assign out_last_byte   = main_beat_r.last;

  // Checks
  `TFG_ASSERT_SAME(a_skid_behind_main, clk, rst_n, skid_valid_r, main_valid_r)
  `TFG_ASSERT_NEXT(a_last_wraps, clk, rst_n, in_accept && gen_last, pos_r == 11'd0)
  `TFG_ASSERT_NEXT(a_pos_steps, clk, rst_n, in_accept && !gen_last, pos_r == $past(eff_pos) + 11'd1)

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the test frame generator: drives restart beats and
// APB register writes, predicts every frame byte, offset and end flag, and
// compares each output beat in order against that prediction.
// ---------------------------------------------------------------------------
module testbench;
  import tfg_pkg::*;

  localparam int unsigned IDLE_PCT     = 37;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  // One output beat
  typedef struct packed {
    logic [7:0]  data;
    logic [10:0] offset;
    logic        last;
  } frame_beat_t;

  // One row of the opening sequence: a register write or an input beat
  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [63:0] data;
    logic        restart;
    logic        typed;
    frame_beat_t want;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_restart;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_frame_byte;
  logic [10:0]       out_byte_offset;
  logic              out_last_byte;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Generator model: register copy, byte position and latched checksums
  tfg_cfg_t     regs;
  int unsigned  gen_pos;
  logic [15:0]  hdr_sum;
  logic [15:0]  l4_sum;

  frame_beat_t  frame_bytes_due[$];
  int unsigned  fault_count;
  logic         steady;
  logic         beat_typed;
  frame_beat_t  typed_beat;

  test_frame_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_byte  (out_frame_byte),
    .out_byte_offset (out_byte_offset),
    .out_last_byte   (out_last_byte),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Frame geometry
  // ---------------------------------------------------------------------------
  function automatic int unsigned payload_len();
    int unsigned p;
    p = regs.frame_mode[10:0];
    return (p > MAX_PAYLOAD) ? MAX_PAYLOAD : p;
  endfunction

  function automatic int unsigned l4_hdr_bytes();
    return (regs.frame_mode[12:11] == PROTO_TCP) ? 20 : 8;
  endfunction

  function automatic int unsigned l4_len();
    return l4_hdr_bytes() + payload_len();
  endfunction

  function automatic int unsigned l4_start();
    return regs.frame_mode[13] ? 54 : 34;
  endfunction

  function automatic logic [7:0] ip_proto();
    if (regs.frame_mode[12:11] == PROTO_UDP) begin
      return IPPROTO_UDP;
    end
    if (regs.frame_mode[12:11] == PROTO_TCP) begin
      return IPPROTO_TCP;
    end
    return regs.frame_mode[13] ? IPPROTO_ICMP6 : IPPROTO_ICMP;
  endfunction

  function automatic int unsigned frame_total();
    int unsigned f;
    f = l4_start() + l4_len();
    return (f < MIN_FRAME) ? MIN_FRAME : f;
  endfunction

  // Byte k of the source or destination IP; IPv4 uses the low 32 bits
  function automatic logic [7:0] ip_addr_byte(logic dst, int unsigned k);
    logic [127:0] a;
    a = dst ? {regs.dest_ip_upper, regs.dest_ip_lower}
            : {regs.source_ip_upper, regs.source_ip_lower};
    if (!regs.frame_mode[13]) begin
      return a[31 - 8*(k % 4) -: 8];
    end
    return a[127 - 8*(k % 16) -: 8];
  endfunction

  // ---------------------------------------------------------------------------
  // Frame byte at position pos, with the given checksums
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] byte_at(int unsigned pos, logic [15:0] hc, logic [15:0] tc);
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] ll;
    logic [15:0] tot;
    int unsigned start;
    int unsigned o;
    logic        is6;
    logic [1:0]  pc;
    sport = regs.flow_ports[31:16];
    dport = regs.flow_ports[15:0];
    ll    = 16'(l4_len());
    tot   = ll + 16'd20;
    start = l4_start();
    is6   = regs.frame_mode[13];
    pc    = regs.frame_mode[12:11];
    if (pos < 6) begin
      return regs.dest_mac[47 - 8*pos -: 8];
    end
    if (pos < 12) begin
      return regs.source_mac[95 - 8*pos -: 8];
    end
    if (pos == 12) begin
      return is6 ? ETYPE6_HI : ETYPE4_HI;
    end
    if (pos == 13) begin
      return is6 ? ETYPE6_LO : ETYPE4_LO;
    end
    // IP header
    if (pos < start) begin
      o = pos - 14;
      if (!is6) begin
        case (o)
          0: return IP4_VER_IHL;
          2: return tot[15:8];
          3: return tot[7:0];
          4: return TAG_HI;
          5: return TAG_LO;
          6: return IP4_FLAG_DF;
          8: return HOP_LIMIT;
          9: return ip_proto();
          10: return hc[15:8];
          11: return hc[7:0];
          default: begin
            if (o >= 12 && o < 16) begin
              return ip_addr_byte(1'b0, o - 12);
            end
            if (o >= 16 && o < 20) begin
              return ip_addr_byte(1'b1, o - 16);
            end
            return 8'h00;
          end
        endcase
      end
      case (o)
        0: return IP6_VER;
        4: return ll[15:8];
        5: return ll[7:0];
        6: return ip_proto();
        7: return HOP_LIMIT;
        default: begin
          if (o >= 8 && o < 24) begin
            return ip_addr_byte(1'b0, o - 8);
          end
          if (o >= 24 && o < 40) begin
            return ip_addr_byte(1'b1, o - 24);
          end
          return 8'h00;
        end
      endcase
    end
    // Transport header, payload fill, then padding
    o = pos - start;
    if (o >= ll) begin
      return 8'h00;
    end
    if (o >= l4_hdr_bytes()) begin
      return PAYLOAD_FILL;
    end
    if (pc == PROTO_UDP) begin
      case (o)
        0: return sport[15:8];
        1: return sport[7:0];
        2: return dport[15:8];
        3: return dport[7:0];
        4: return ll[15:8];
        5: return ll[7:0];
        6: return tc[15:8];
        default: return tc[7:0];
      endcase
    end
    if (pc == PROTO_TCP) begin
      case (o)
        0: return sport[15:8];
        1: return sport[7:0];
        2: return dport[15:8];
        3: return dport[7:0];
        4: return TAG_HI;
        5: return TAG_LO;
        6: return TCP_SEQ_B2;
        7: return TCP_SEQ_B3;
        12: return TCP_DOFF;
        13: return TCP_SYN;
        14, 15: return TCP_WIN;
        16: return tc[15:8];
        17: return tc[7:0];
        default: return 8'h00;
      endcase
    end
    // ICMP echo, also for protocol code three
    case (o)
      0: return is6 ? ICMP6_ECHO : ICMP4_ECHO;
      2: return tc[15:8];
      3: return tc[7:0];
      4: return sport[15:8];
      5: return sport[7:0];
      6: return dport[15:8];
      7: return dport[7:0];
      default: return 8'h00;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Internet checksum helpers
  // ---------------------------------------------------------------------------
  // Big-endian 16-bit word sum over frame bytes, checksum fields taken as zero
  function automatic logic [31:0] word_sum(logic [31:0] acc, int unsigned first,
                                           int unsigned count);
    logic [7:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      b = byte_at(first + i, 16'h0000, 16'h0000);
      acc += (i % 2) ? 32'(b) : (32'(b) << 8);
    end
    return acc;
  endfunction

  function automatic logic [15:0] fold_sum(logic [31:0] s);
    while (s[31:16] != 16'h0000) begin
      s = {16'h0000, s[15:0]} + {16'h0000, s[31:16]};
    end
    return ~s[15:0];
  endfunction

  // L4 checksum before the UDP zero substitution; ICMPv4 has no pseudo-header
  function automatic logic [15:0] l4_csum_raw();
    logic [31:0] ps;
    int unsigned n;
    int unsigned sh;
    ps = 32'h0;
    if (regs.frame_mode[12:11] != PROTO_ICMP || regs.frame_mode[13]) begin
      n = regs.frame_mode[13] ? 16 : 4;
      for (int unsigned i = 0; i < n; i++) begin
        sh = (i % 2) ? 0 : 8;
        ps += 32'(ip_addr_byte(1'b0, i)) << sh;
        ps += 32'(ip_addr_byte(1'b1, i)) << sh;
      end
      ps += l4_len();
      ps += 32'(ip_proto());
    end
    return fold_sum(word_sum(ps, l4_start(), l4_len()));
  endfunction

  // Advance the generator model by one input beat
  function automatic frame_beat_t next_frame_beat(logic restart);
    int unsigned flen;
    logic [15:0] c;
    frame_beat_t b;
    flen = frame_total();
    if (restart || gen_pos >= flen) begin
      gen_pos = 0;
    end
    // checksums latch at byte zero only
    if (gen_pos == 0) begin
      hdr_sum = regs.frame_mode[13] ? 16'h0000 : fold_sum(word_sum(32'h0, 14, 20));
      c = l4_csum_raw();
      if (regs.frame_mode[12:11] == PROTO_UDP && c == 16'h0000) begin
        c = UDP_ZERO_CSUM;
      end
      l4_sum = c;
    end
    b.data   = byte_at(gen_pos, hdr_sum, l4_sum);
    b.offset = 11'(gen_pos);
    b.last   = (gen_pos + 1 == flen);
    gen_pos  = b.last ? 0 : gen_pos + 1;
    return b;
  endfunction

  function automatic int unsigned idle_pct();
    return steady ? 0 : IDLE_PCT;
  endfunction

  function automatic void report_fault(string what, frame_beat_t want, frame_beat_t got);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%0t %s: want byte %h off %0d last %b, got byte %h off %0d last %b",
               $realtime, what, want.data, want.offset, want.last,
               got.data, got.offset, got.last);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction on input beats, checking on output beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_beat_t want;
    frame_beat_t got;
    if (rst_n && in_valid && !in_stall) begin
      want = next_frame_beat(in_restart);
      if (beat_typed) begin
        want = typed_beat;
      end
      frame_bytes_due.push_back(want);
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_frame_byte, out_byte_offset, out_last_byte};
      if (frame_bytes_due.size() == 0) begin
        report_fault("unexpected beat", '0, got);
      end else begin
        want = frame_bytes_due.pop_front();
        if (got.data !== want.data || got.offset !== want.offset
            || got.last !== want.last) begin
          report_fault("mismatch", want, got);
        end
      end
    end
  end

  // Receiver backpressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(0, 99) < idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers, all called at a falling edge
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DEST_MAC:   regs.dest_mac        = val[47:0];
      REG_SOURCE_MAC: regs.source_mac      = val[47:0];
      REG_SRC_IP_UP:  regs.source_ip_upper = val;
      REG_SRC_IP_LO:  regs.source_ip_lower = val;
      REG_DST_IP_UP:  regs.dest_ip_upper   = val;
      REG_DST_IP_LO:  regs.dest_ip_lower   = val;
      REG_FLOW_PORTS: regs.flow_ports      = val[31:0];
      default:        regs.frame_mode      = val[13:0];
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Hold valid until the beat is taken; returns at the next falling edge
  task automatic send_beat(input logic restart, input logic typed, input frame_beat_t want);
    while ($urandom_range(0, 99) < idle_pct()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_restart = restart;
    beat_typed = typed;
    typed_beat = want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (frame_bytes_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [63:0] random_reg_value(logic [2:0] idx, logic udp_only);
    logic [63:0] v;
    int unsigned sel;
    int unsigned pay;
    v   = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      v = '1;
    end else if (sel == 1) begin
      v = '0;
    end
    // mostly short frames, now and then long or saturated payloads
    if (idx == REG_FRAME_MODE) begin
      sel = $urandom_range(0, 19);
      if (sel < 16) begin
        pay = $urandom_range(0, 120);
      end else if (sel < 18) begin
        pay = $urandom_range(121, MAX_PAYLOAD);
      end else if (sel == 18) begin
        pay = MAX_PAYLOAD;
      end else begin
        pay = $urandom_range(MAX_PAYLOAD + 1, 2047);
      end
      v[10:0] = 11'(pay);
      if (udp_only) begin
        v[12:11] = PROTO_UDP;
      end
    end
    return v;
  endfunction

  // Rewrite some registers; optionally steer the UDP checksum to zero
  task automatic configure_phase(input logic udp_zero);
    for (int r = 0; r < 8; r++) begin
      if (r == REG_FRAME_MODE || $urandom_range(0, 1) == 1) begin
        write_reg(3'(r), random_reg_value(3'(r), udp_zero));
      end
    end
    // with source port zero the raw sum is ~c; sport = c folds it to zero
    if (udp_zero) begin
      regs.flow_ports[31:16] = 16'h0000;
      write_reg(REG_FLOW_PORTS, {32'h0, l4_csum_raw(), regs.flow_ports[15:0]});
    end
  endtask

  function automatic plan_row_t cfg_row(logic [2:0] idx, logic [63:0] val);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = val;
    return r;
  endfunction

  function automatic plan_row_t beat_row(logic restart);
    plan_row_t r;
    r         = '0;
    r.restart = restart;
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic restart, logic [7:0] b, logic [10:0] off,
                                          logic last);
    plan_row_t r;
    r         = '0;
    r.restart = restart;
    r.typed   = 1'b1;
    r.want    = '{b, off, last};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t   plan[$];
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    logic        noisy;
    logic        crafted;
    logic        restart;
    logic [63:0] mode;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_restart = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    beat_typed = 1'b0;
    typed_beat = '0;
    steady     = 1'b0;
    fault_count = 0;
    regs       = '0;
    regs.frame_mode = FRAME_MODE_RESET;
    gen_pos    = 0;
    hdr_sum    = 16'h0000;
    l4_sum     = 16'h0000;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    plan = '{
      // reset values: zero MACs, IPv4 UDP
      typed_row(1'b0, 8'h00, 11'd0, 1'b0),
      typed_row(1'b0, 8'h00, 11'd1, 1'b0),
      cfg_row(REG_DEST_MAC, 64'hffff_ffff_ffff_ffff),
      typed_row(1'b1, 8'hff, 11'd0, 1'b0),
      typed_row(1'b0, 8'hff, 11'd1, 1'b0),
      cfg_row(REG_SOURCE_MAC, 64'h0000_0200_5e10_2030),
      beat_row(1'b0),                                   // continues after a mid-frame write
      cfg_row(REG_SRC_IP_UP, 64'hfe80_0000_0000_0000),
      cfg_row(REG_SRC_IP_LO, 64'h0000_0000_c0a8_0001),
      cfg_row(REG_DST_IP_UP, 64'hffff_ffff_ffff_ffff),
      cfg_row(REG_DST_IP_LO, 64'h0000_0000_0000_0000),
      cfg_row(REG_FLOW_PORTS, 64'h0000_0000_ffff_0000),
      cfg_row(REG_FRAME_MODE, 64'h0000),                // IPv4 UDP, empty payload
      beat_row(1'b1), beat_row(1'b0),
      cfg_row(REG_FRAME_MODE, 64'h0801),                // IPv4 TCP
      beat_row(1'b1), beat_row(1'b0),
      cfg_row(REG_FRAME_MODE, 64'h1000),                // ICMPv4
      beat_row(1'b1), beat_row(1'b0),
      cfg_row(REG_FRAME_MODE, 64'h1d79),                // code three, payload saturates
      beat_row(1'b1), beat_row(1'b0),
      cfg_row(REG_FRAME_MODE, 64'h3fff),                // all mode bits set
      beat_row(1'b1), beat_row(1'b0),
      cfg_row(REG_FRAME_MODE, 64'h3578),                // ICMPv6, max payload
      beat_row(1'b1), beat_row(1'b0),
      cfg_row(REG_FRAME_MODE, 64'h2800),                // IPv6 TCP
      beat_row(1'b1), beat_row(1'b0)
    };

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_beat(plan[i].restart, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: new settings while idle, then a run of beats
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      steady  = (phase >= 2 && phase < 5);
      crafted = (phase % 5 == 2);
      configure_phase(crafted);
      n       = crafted ? $urandom_range(70, 110) : $urandom_range(20, 60);
      noisy   = ($urandom_range(0, 9) < 3);
      for (int unsigned k = 0; k < n; k++) begin
        if (crafted && k == 0) begin
          restart = 1'b1;
        end else if (noisy) begin
          restart = ($urandom_range(0, 3) == 0);
        end else begin
          restart = ($urandom_range(0, 99) == 0);
        end
        send_beat(restart, 1'b0, '0);
      end
      sent  += n;
      phase++;
    end

    // One full frame at saturated payload length, through its last byte
    drain_results();
    steady = 1'b0;
    mode = 64'h7ff;
    mode[13] = 1'($urandom_range(0, 1));
    mode[12:11] = 2'($urandom_range(0, 3));
    write_reg(REG_FRAME_MODE, mode);
    n = frame_total() + 4;
    for (int unsigned k = 0; k < n; k++) begin
      send_beat(k == 0, 1'b0, '0);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/tfg_pkg.sv
hdl/tfg_byte_gen.sv
hdl/tfg_csum.sv
hdl/test_frame_generator.sv
test/testbench.sv
